// ===== hdl/parameterless_instance_scheduler_assert.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef PARAMETERLESS_INSTANCE_SCHEDULER_ASSERT_SVH
`define PARAMETERLESS_INSTANCE_SCHEDULER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge out of reset.
`define PIS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define PIS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PIS_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define PIS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hdl/pis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pis_pkg;

    localparam int MAX_INST = 16;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int FIT_W    = 32;
    localparam int SIZE_W   = 32;
    localparam int DIGIT_W  = 4;
    localparam int BASE_W   = 5;
    localparam int MULT_W   = 5;
    localparam int FIRST_W  = 21;
    localparam int ADDR_W   = 4;

    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_REPORT   = 1'b1;

    typedef enum logic [1:0] {
        REG_COUNTER_BASE    = 2'd0,
        REG_SIZE_MULTIPLIER = 2'd1,
        REG_FIRST_POP_SIZE  = 2'd2,
        REG_UNUSED          = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [MULT_W-1:0]  mult;
        logic [FIRST_W-1:0] first_size;
        logic               load_first;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK,
        ST_SCHED_END,
        ST_UP_RD,
        ST_UP,
        ST_DN_RD,
        ST_DN,
        ST_CMP_RD,
        ST_CMP_WR,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== hdl/pis_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pis_cfg
    import pis_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [BASE_W-1:0]  base_reg;
    logic [MULT_W-1:0]  mult_reg;
    logic [FIRST_W-1:0] first_reg;
    logic               load_reg;
    logic               wr_en;
    reg_index_t         sel;

    assign pready = 1'b1;
    assign sel    = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= BASE_W'(4);
            mult_reg  <= MULT_W'(2);
            first_reg <= FIRST_W'(16);
            load_reg  <= 1'b0;
        end else begin
            load_reg <= 1'b0;
            if (wr_en) begin
                case (sel)
                    REG_COUNTER_BASE:    base_reg <= pwdata[BASE_W-1:0];
                    REG_SIZE_MULTIPLIER: mult_reg <= pwdata[MULT_W-1:0];
                    REG_FIRST_POP_SIZE: begin
                        first_reg <= pwdata[FIRST_W-1:0];
                        load_reg  <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (sel)
            REG_COUNTER_BASE:    prdata = {{(32-BASE_W){1'b0}}, base_reg};
            REG_SIZE_MULTIPLIER: prdata = {{(32-MULT_W){1'b0}}, mult_reg};
            REG_FIRST_POP_SIZE:  prdata = {{(32-FIRST_W){1'b0}}, first_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.base       = base_reg;
    assign cfg.mult       = mult_reg;
    assign cfg.first_size = first_reg;
    assign cfg.load_first = load_reg;

endmodule
`default_nettype wire

// ===== hdl/pis_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pis_ctrl
    import pis_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_cmd,
    input  wire logic [FIT_W-1:0]  in_fitness,
    input  wire logic              in_steady,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [IDX_W-1:0]       out_run,
    output logic                   out_add,
    output logic [SIZE_W-1:0]      out_size,
    output logic [MAX_INST-1:0]    out_mask,
    output logic [CNT_W-1:0]       out_live,
    output logic                   out_full
);

    // True when d is a nonzero multiple of b (d at most 16, b at least 2).
    function automatic logic is_mult(input logic [CNT_W-1:0] d, input logic [BASE_W-1:0] b);
        logic r;
        r = 1'b0;
        for (int k = 1; k <= 8; k++) begin
            if ({3'b0, d} == 8'(k) * {3'b0, b}) r = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [MAX_INST-1:0] low_bits(input logic [CNT_W-1:0] n);
        logic [MAX_INST:0] t;
        t = ({{MAX_INST{1'b0}}, 1'b1} << n) - 1'b1;
        return t[MAX_INST-1:0];
    endfunction

    // Digit and fitness memories, one write and one registered read each.
    logic [DIGIT_W-1:0] dig_mem [MAX_INST];
    logic [FIT_W-1:0]   fit_mem [MAX_INST];
    logic               dig_we, fit_we;
    logic [IDX_W-1:0]   dig_waddr, dig_raddr, fit_waddr, fit_raddr;
    logic [DIGIT_W-1:0] dig_wdata, dig_rdata;
    logic [FIT_W-1:0]   fit_wdata, fit_rdata;

    always_ff @(posedge aclk) begin
        if (dig_we) dig_mem[dig_waddr] <= dig_wdata;
        dig_rdata <= dig_mem[dig_raddr];
    end

    always_ff @(posedge aclk) begin
        if (fit_we) fit_mem[fit_waddr] <= fit_wdata;
        fit_rdata <= fit_mem[fit_raddr];
    end

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    i_reg, i_next, j_reg, j_next, idx_reg, idx_next;
    logic [CNT_W-1:0]    dcount_reg, dcount_next, total_reg, total_next;
    logic [IDX_W-1:0]    last_reg, last_next;
    logic [SIZE_W-1:0]   nsize_reg, nsize_next;
    logic [FIT_W-1:0]    key_reg, key_next;
    logic [MAX_INST-1:0] mask_reg, mask_next;
    logic [IDX_W-1:0]    res_run_reg, res_run_next;
    logic                res_add_reg, res_add_next, res_full_reg, res_full_next;
    logic [SIZE_W-1:0]   res_size_reg, res_size_next;
    logic                oval_reg, oval_next;
    logic [IDX_W-1:0]    orun_reg;
    logic                oadd_reg, ofull_reg;
    logic [SIZE_W-1:0]   osize_reg;
    logic [MAX_INST-1:0] omask_reg;
    logic [CNT_W-1:0]    olive_reg;

    logic                accept, out_free, carry, ext, need_add, can_add;
    logic                rpt_live, up_start, up_hit, dn_hit, keep;
    logic [BASE_W-1:0]   base;
    logic [CNT_W-1:0]    i_inc, i_dec, last_inc, d_inc, run_sat;
    logic [SIZE_W+MULT_W-1:0] prod;
    logic [SIZE_W-1:0]   prod_sat;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !oval_reg || out_ready;

    assign base = (cfg.base < BASE_W'(2)) ? BASE_W'(2) :
                  (cfg.base > BASE_W'(16)) ? BASE_W'(16) : cfg.base;

    assign i_inc    = i_reg + 1'b1;
    assign i_dec    = i_reg - 1'b1;
    assign last_inc = {1'b0, last_reg} + 1'b1;
    assign d_inc    = {1'b0, dig_rdata} + 1'b1;
    assign carry    = is_mult(d_inc, base);
    assign ext      = (idx_reg == dcount_reg) && (dcount_reg < CNT_W'(MAX_INST));
    assign need_add = (idx_reg == total_reg);
    assign can_add  = (total_reg < CNT_W'(MAX_INST));
    assign run_sat  = (idx_reg > CNT_W'(MAX_INST - 1)) ? CNT_W'(MAX_INST - 1) : idx_reg;
    assign rpt_live = ({1'b0, last_reg} < total_reg);
    assign up_start = (last_inc < total_reg);
    assign up_hit   = $signed(key_reg) < $signed(fit_rdata);
    assign dn_hit   = $signed(fit_rdata) < $signed(key_reg);
    assign keep     = !mask_reg[i_reg[IDX_W-1:0]];
    assign prod     = {{MULT_W{1'b0}}, nsize_reg} * {{SIZE_W{1'b0}}, cfg.mult};
    assign prod_sat = (|prod[SIZE_W+MULT_W-1:SIZE_W]) ? {SIZE_W{1'b1}} : prod[SIZE_W-1:0];

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_SCHEDULE) begin
                        state_next = (dcount_reg == '0) ? ST_SCHED_END : ST_WALK_RD;
                    end else if (!rpt_live) begin
                        state_next = ST_DONE;
                    end else if (in_steady) begin
                        state_next = ST_CMP_RD;
                    end else if (up_start) begin
                        state_next = ST_UP_RD;
                    end else if (last_reg != '0) begin
                        state_next = ST_DN_RD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WALK_RD:   state_next = ST_WALK;
            ST_WALK:      state_next = (carry && (i_inc < dcount_reg)) ? ST_WALK_RD
                                                                      : ST_SCHED_END;
            ST_SCHED_END: state_next = ST_DONE;
            ST_UP_RD:     state_next = ST_UP;
            ST_UP: begin
                if (up_hit) begin
                    state_next = ST_CMP_RD;
                end else if (i_inc < total_reg) begin
                    state_next = ST_UP_RD;
                end else if (last_reg != '0) begin
                    state_next = ST_DN_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DN_RD:     state_next = ST_DN;
            ST_DN: begin
                if (dn_hit) begin
                    state_next = ST_CMP_RD;
                end else if (i_reg > CNT_W'(1)) begin
                    state_next = ST_DN_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP_RD:    state_next = ST_CMP_WR;
            ST_CMP_WR:    state_next = (i_inc < total_reg) ? ST_CMP_RD : ST_DONE;
            ST_DONE:      state_next = out_free ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory ports.
    always_comb begin
        i_next        = i_reg;
        j_next        = j_reg;
        idx_next      = idx_reg;
        dcount_next   = dcount_reg;
        total_next    = total_reg;
        last_next     = last_reg;
        nsize_next    = cfg.load_first ? {{(SIZE_W-FIRST_W){1'b0}}, cfg.first_size} : nsize_reg;
        key_next      = key_reg;
        mask_next     = mask_reg;
        res_run_next  = res_run_reg;
        res_add_next  = res_add_reg;
        res_size_next = res_size_reg;
        res_full_next = res_full_reg;
        oval_next     = oval_reg && !out_ready;
        dig_we        = 1'b0;
        dig_waddr     = i_reg[IDX_W-1:0];
        dig_wdata     = '0;
        dig_raddr     = i_reg[IDX_W-1:0];
        fit_we        = 1'b0;
        fit_waddr     = last_reg;
        fit_wdata     = in_fitness;
        fit_raddr     = i_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_add_next  = 1'b0;
                    res_size_next = '0;
                    res_full_next = 1'b0;
                    mask_next     = '0;
                    if (in_cmd == CMD_SCHEDULE) begin
                        i_next   = '0;
                        idx_next = '0;
                        if (dcount_reg == '0) begin
                            dig_we      = 1'b1;
                            dig_waddr   = '0;
                            dig_wdata   = '0;
                            dcount_next = CNT_W'(1);
                        end
                    end else begin
                        res_run_next = last_reg;
                        if (rpt_live) begin
                            fit_we   = 1'b1;
                            key_next = in_fitness;
                            j_next   = '0;
                            if (in_steady) begin
                                mask_next = {{(MAX_INST-1){1'b0}}, 1'b1} << last_reg;
                                i_next    = '0;
                            end else if (up_start) begin
                                i_next = last_inc;
                            end else begin
                                i_next = {1'b0, last_reg};
                            end
                        end
                    end
                end
            end
            ST_WALK: begin
                dig_we = 1'b1;
                if (carry) begin
                    dig_wdata = '0;
                    idx_next  = i_inc;
                    i_next    = i_inc;
                end else begin
                    dig_wdata = d_inc[DIGIT_W-1:0];
                end
            end
            ST_SCHED_END: begin
                if (ext) begin
                    dig_we      = 1'b1;
                    dig_waddr   = dcount_reg[IDX_W-1:0];
                    dig_wdata   = DIGIT_W'(1);
                    dcount_next = dcount_reg + 1'b1;
                end
                if (need_add) begin
                    if (can_add) begin
                        fit_we        = 1'b1;
                        fit_waddr     = total_reg[IDX_W-1:0];
                        fit_wdata     = '0;
                        total_next    = total_reg + 1'b1;
                        res_add_next  = 1'b1;
                        res_size_next = nsize_reg;
                        nsize_next    = prod_sat;
                    end else begin
                        res_full_next = 1'b1;
                    end
                end
                last_next    = run_sat[IDX_W-1:0];
                res_run_next = run_sat[IDX_W-1:0];
            end
            ST_UP_RD: fit_raddr = i_reg[IDX_W-1:0];
            ST_UP: begin
                if (up_hit) begin
                    mask_next = low_bits(last_inc);
                    i_next    = '0;
                end else if (i_inc < total_reg) begin
                    i_next = i_inc;
                end else begin
                    i_next = {1'b0, last_reg};
                end
            end
            ST_DN_RD: fit_raddr = i_dec[IDX_W-1:0];
            ST_DN: begin
                if (dn_hit) begin
                    mask_next = low_bits(i_reg);
                    i_next    = '0;
                end else begin
                    i_next = i_dec;
                end
            end
            ST_CMP_RD: fit_raddr = i_reg[IDX_W-1:0];
            ST_CMP_WR: begin
                if (keep) begin
                    fit_we    = 1'b1;
                    fit_waddr = j_reg[IDX_W-1:0];
                    fit_wdata = fit_rdata;
                end
                j_next = j_reg + CNT_W'(keep);
                i_next = i_inc;
                if (!(i_inc < total_reg)) begin
                    total_next  = j_reg + CNT_W'(keep);
                    dcount_next = '0;
                    last_next   = '0;
                end
            end
            ST_DONE: begin
                if (out_free) oval_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            dcount_reg <= '0;
            total_reg  <= '0;
            last_reg   <= '0;
            nsize_reg  <= SIZE_W'(16);
            oval_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            dcount_reg <= dcount_next;
            total_reg  <= total_next;
            last_reg   <= last_next;
            nsize_reg  <= nsize_next;
            oval_reg   <= oval_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        idx_reg      <= idx_next;
        key_reg      <= key_next;
        mask_reg     <= mask_next;
        res_run_reg  <= res_run_next;
        res_add_reg  <= res_add_next;
        res_size_reg <= res_size_next;
        res_full_reg <= res_full_next;
        if (state_reg == ST_DONE && out_free) begin
            orun_reg  <= res_run_reg;
            oadd_reg  <= res_add_reg;
            osize_reg <= res_size_reg;
            omask_reg <= mask_reg;
            olive_reg <= total_reg;
            ofull_reg <= res_full_reg;
        end
    end

    assign out_valid = oval_reg;
    assign out_run   = orun_reg;
    assign out_add   = oadd_reg;
    assign out_size  = osize_reg;
    assign out_mask  = omask_reg;
    assign out_live  = olive_reg;
    assign out_full  = ofull_reg;

endmodule
`default_nettype wire

// ===== hdl/parameterless_instance_scheduler.sv =====
// Sequencing: a schedule reads and writes back each digit read by the carry walk (none
// after a cleared counter, at most 16) before its result; a stale report goes straight to
// its result, and any other report may scan entries and then compact the table, with a read
// state before each entry because each fitness memory read is registered.
// Throughput: one transaction at a time; the next is taken after the result is registered.
// Reset: synchronous, active low; the counter and instance table read as empty and all
// configuration registers return to their reset values. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "parameterless_instance_scheduler_assert.svh"
module parameterless_instance_scheduler
    import pis_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Input transactions.
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [39:0]       s_tdata,   // [31:0] avg_fitness, [32] is_steady, rest zero
    input  wire logic              s_tuser,   // [0] cmd
    // Result transactions.
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [3:0] run_index, [4] add_instance, [36:5] new_pop_size, [52:37] delete_mask,
    // [57:53] live_count, [58] table_full, [63:59] zero
    output logic [63:0]            m_tdata,
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // The configuration block holds the three registers and pulses a load
    // of the next population size whenever the first size is written.
    cfg_t cfg;

    pis_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The controller owns the digit memory and the fitness memory. A schedule
    // walks the digits least significant first, one read and one write-back per
    // digit, and then appends an instance if the carry reached the table end and room remains.
    // A live report writes the fitness, scans upward and then downward for the deletion
    // decision unless steady, and compacts the table in place when anything goes.
    logic [IDX_W-1:0]    run_index;
    logic                add_instance;
    logic [SIZE_W-1:0]   new_pop_size;
    logic [MAX_INST-1:0] delete_mask;
    logic [CNT_W-1:0]    live_count;
    logic                table_full;

    pis_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_fitness (s_tdata[FIT_W-1:0]),
        .in_steady  (s_tdata[FIT_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_run    (run_index),
        .out_add    (add_instance),
        .out_size   (new_pop_size),
        .out_mask   (delete_mask),
        .out_live   (live_count),
        .out_full   (table_full)
    );

    // Results are packed lowest field first, padded with zeros to 64 bits.
    assign m_tdata = {5'd0, table_full, live_count, delete_mask, new_pop_size,
                      add_instance, run_index};

    // A result never both adds an instance and reports a full table.
    `PIS_ASSERT_IMP(a_add_xor_full, aclk, aresetn, m_tvalid,
        !(add_instance && table_full), "add and full together")
    // Deletions come only from reports, which never add an instance.
    `PIS_ASSERT_IMP(a_delete_no_add, aclk, aresetn, m_tvalid && (delete_mask != '0),
        !add_instance, "delete with add")
    // Accepting a transaction takes the controller out of the idle state, which closes the input.
    `PIS_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready,
        !s_tready, "input not closed")
    // The live count never exceeds the table size.
    `PIS_ASSERT_IMP(a_live_bound, aclk, aresetn, m_tvalid,
        live_count <= CNT_W'(MAX_INST), "live count too big")

endmodule
`default_nettype wire
